### rtl/core/efrs_pkg.sv
// Shared constants, codes and types for the encoder frame receiver and speed estimator.
// Used by efrs_ctrl, efrs_dp and encoder_frame_receiver_speed. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efrs_pkg;

    // Encoder count and derived index width
    localparam int NUM_ENC = 4;
    localparam int ENC_W   = (NUM_ENC > 1) ? $clog2(NUM_ENC) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int IVL_W   = 16;
    localparam int SPEED_W = 48;

    // Frame format
    localparam logic [7:0] FRAME_HDR   = 8'hAA;
    localparam int         FRAME_BYTES = 16;
    localparam int         CNT_W       = $clog2(FRAME_BYTES);

    // Opcodes
    localparam logic [OP_W-1:0] OP_BYTE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SPEED  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESYNC = 2'd2;

    // Arithmetic
    localparam logic [19:0]      US_PER_S    = 20'd1000000;
    localparam logic [IVL_W-1:0] MIN_IVL_RST = 16'd1000;
    localparam int               PROD_W      = 52;
    localparam int               DIV_STEPS   = PROD_W;
    localparam int               DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PROD_W-1:0]  POS_LIM   = PROD_W'({1'b0, {(SPEED_W-1){1'b1}}});
    localparam logic [PROD_W-1:0]  NEG_LIM   = POS_LIM + PROD_W'(1);
    localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic take_byte;
        logic resync;
        logic start;
        logic check;
        logic mul;
        logic div_step;
        logic finish;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic short_ivl;
    } t_stat;

endpackage

`default_nettype wire

### rtl/core/efrs_ctrl.sv
// Controller state machine: input/output handshake, sequencing of the speed calculation.
// Depends on efrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efrs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [efrs_pkg::OP_W-1:0]  i_opcode,
    input  logic                       i_out_stall,
    input  efrs_pkg::t_stat            i_stat,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output efrs_pkg::t_cmd             o_cmd,
    output efrs_pkg::t_state           o_state
);
    import efrs_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_upd;
    logic                   r_out_valid;
    logic                   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_opcode == OP_SPEED)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = i_stat.short_ivl ? S_FIN : S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_BYTE:   o_cmd.take_byte = 1'b1;
                        OP_SPEED:  o_cmd.start     = 1'b1;
                        OP_RESYNC: o_cmd.resync    = 1'b1;
                        default:   o_cmd           = '0;
                    endcase
                end
            end
            S_CHECK: o_cmd.check    = 1'b1;
            S_MUL:   o_cmd.mul      = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_FIN: begin
                o_cmd.finish = w_out_free;
                o_cmd.upd    = r_upd;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            if (r_state == S_CHECK) begin
                r_upd <= !i_stat.short_ivl;
            end
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

`default_nettype wire

### rtl/core/efrs_dp.sv
// Datapath: frame assembly, position and tracker registers, multiplier, serial divider,
// saturation and output register. Depends on efrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efrs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efrs_pkg::t_cmd                i_cmd,
    input  logic [7:0]                    i_data_byte,
    input  logic [efrs_pkg::IDX_W-1:0]    i_encoder_index,
    input  logic [efrs_pkg::TIME_W-1:0]   i_time_us,
    input  logic                          i_cfg_we,
    input  logic [efrs_pkg::IVL_W-1:0]    i_cfg_data,
    output efrs_pkg::t_stat               o_stat,
    output logic signed [efrs_pkg::POS_W-1:0]   o_position,
    output logic signed [efrs_pkg::SPEED_W-1:0] o_speed_pps,
    output logic                          o_speed_updated
);
    import efrs_pkg::*;

    localparam int STAGE_W = (FRAME_BYTES - 1) * 8;

    // Configuration and frame state
    logic [IVL_W-1:0]        r_min_ivl;
    logic                    r_collect;
    logic [CNT_W-1:0]        r_byte_cnt;
    logic [STAGE_W-1:0]      r_stage;
    logic [FRAME_BYTES*8-1:0] w_frame;

    // Per-encoder state
    logic [POS_W-1:0]        r_pos_tab   [NUM_ENC];
    logic [POS_W-1:0]        r_tpos_tab  [NUM_ENC];
    logic [TIME_W-1:0]       r_ttime_tab [NUM_ENC];
    logic [SPEED_W-1:0]      r_tspd_tab  [NUM_ENC];

    // Working registers of one speed request
    logic [ENC_W-1:0]        w_sel;
    logic [ENC_W-1:0]        r_sel;
    logic [TIME_W-1:0]       r_now;
    logic [TIME_W-1:0]       r_dt;
    logic [POS_W-1:0]        r_pos;
    logic [POS_W:0]          r_delta;
    logic [POS_W-1:0]        r_mag;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_quo;
    logic [TIME_W-1:0]       r_rem;
    logic [TIME_W:0]         w_trial;
    logic                    w_ge;
    logic [SPEED_W-1:0]      w_sat;

    // Output register
    logic [POS_W-1:0]        r_out_pos;
    logic [SPEED_W-1:0]      r_out_speed;
    logic                    r_out_upd;

    // Out-of-range index falls back to encoder 0
    assign w_sel = (32'(i_encoder_index) < NUM_ENC) ? ENC_W'(i_encoder_index) : '0;

    assign w_frame = {i_data_byte, r_stage};

    assign o_stat.short_ivl = (r_dt == '0) || (r_dt < TIME_W'(r_min_ivl));

    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dt};

    always_comb begin
        if (r_neg) begin
            w_sat = (r_quo > NEG_LIM) ? SPEED_MIN : SPEED_W'(-r_quo[SPEED_W-1:0]);
        end else begin
            w_sat = (r_quo > POS_LIM) ? SPEED_MAX : r_quo[SPEED_W-1:0];
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ivl  <= MIN_IVL_RST;
            r_collect  <= 1'b0;
            r_byte_cnt <= '0;
            for (int e = 0; e < NUM_ENC; e++) begin
                r_pos_tab[e]   <= '0;
                r_tpos_tab[e]  <= '0;
                r_ttime_tab[e] <= '0;
                r_tspd_tab[e]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_min_ivl <= i_cfg_data;
            end
            if (i_cmd.take_byte) begin
                if (!r_collect) begin
                    if (i_data_byte == FRAME_HDR) begin
                        r_collect  <= 1'b1;
                        r_byte_cnt <= '0;
                    end
                end else if (r_byte_cnt == CNT_W'(FRAME_BYTES - 1)) begin
                    for (int e = 0; e < NUM_ENC; e++) begin
                        if (e < 4) begin
                            r_pos_tab[e] <= w_frame[e*POS_W +: POS_W];
                        end
                    end
                    r_collect  <= 1'b0;
                    r_byte_cnt <= '0;
                end else begin
                    r_byte_cnt <= r_byte_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.resync) begin
                r_tpos_tab[w_sel]  <= r_pos_tab[w_sel];
                r_ttime_tab[w_sel] <= i_time_us;
                r_tspd_tab[w_sel]  <= '0;
            end
            if (i_cmd.finish && i_cmd.upd) begin
                r_tpos_tab[r_sel]  <= r_pos;
                r_ttime_tab[r_sel] <= r_now;
                r_tspd_tab[r_sel]  <= w_sat;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && r_collect) begin
            r_stage <= {i_data_byte, r_stage[STAGE_W-1:8]};
        end
        if (i_cmd.start) begin
            r_sel   <= w_sel;
            r_now   <= i_time_us;
            r_dt    <= i_time_us - r_ttime_tab[w_sel];
            r_pos   <= r_pos_tab[w_sel];
            r_delta <= {r_pos_tab[w_sel][POS_W-1], r_pos_tab[w_sel]}
                     - {r_tpos_tab[w_sel][POS_W-1], r_tpos_tab[w_sel]};
        end
        if (i_cmd.check) begin
            r_neg <= r_delta[POS_W];
            r_mag <= r_delta[POS_W] ? POS_W'(-r_delta) : r_delta[POS_W-1:0];
        end
        if (i_cmd.mul) begin
            r_quo <= PROD_W'(r_mag * US_PER_S);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? TIME_W'(w_trial - {1'b0, r_dt}) : w_trial[TIME_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
        if (i_cmd.finish) begin
            r_out_pos   <= r_pos;
            r_out_speed <= i_cmd.upd ? w_sat : r_tspd_tab[r_sel];
            r_out_upd   <= i_cmd.upd;
        end
    end

    assign o_position      = r_out_pos;
    assign o_speed_pps     = r_out_speed;
    assign o_speed_updated = r_out_upd;

endmodule

`default_nettype wire

### rtl/core/encoder_frame_receiver_speed.sv
// Top level of the encoder frame receiver and speed estimator.
// Instantiates efrs_ctrl and efrs_dp; depends on efrs_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per item: opcode, data
//   byte, encoder index and microsecond time. A word is taken at a clock edge with
//   i_in_valid high and o_in_stall low.
//   Opcode 0 feeds a UART byte to the frame parser (header 0xAA, then 16 bytes of four
//   little-endian positions, committed together on the last byte). Opcode 2 resyncs one
//   tracker. Both return nothing. Opcode 3 is dropped.
//   Opcode 1 returns one word on the output channel (o_out_valid / i_out_stall).
//   A repeated speed (interval too short) goes from the interval check straight to the
//   final state; a new estimate first passes the multiply and the 52-step bit-serial divider.
//   The input is stalled for the duration of a speed request, until its result enters the
//   output register; other words go at one per cycle while no speed request is in progress.
//   The output register holds a result while i_out_stall is high; bytes and resyncs
//   keep flowing, and a later result waits in its final state until the register frees.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes min_interval_us.
//   Synchronous active-low reset clears positions, trackers and the parser, and sets
//   the minimum interval to 1000 us.
`timescale 1ns / 1ps
`default_nettype none

module encoder_frame_receiver_speed (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [efrs_pkg::OP_W-1:0]           i_opcode,
    input  logic [7:0]                          i_data_byte,
    input  logic [efrs_pkg::IDX_W-1:0]          i_encoder_index,
    input  logic [efrs_pkg::TIME_W-1:0]         i_time_us,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [efrs_pkg::POS_W-1:0]   o_position,
    output logic signed [efrs_pkg::SPEED_W-1:0] o_speed_pps,
    output logic                                o_speed_updated,
    // Configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [efrs_pkg::IVL_W-1:0]          i_cfg_data
);
    import efrs_pkg::*;

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;
    logic   w_cfg_we;

    // Register write is always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    efrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    efrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_data_byte),
        .i_encoder_index (i_encoder_index),
        .i_time_us       (i_time_us),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (w_stat),
        .o_position      (o_position),
        .o_speed_pps     (o_speed_pps),
        .o_speed_updated (o_speed_updated)
    );

`ifndef SYNTHESIS
    // A result only shows up after the final state of a speed request
    a_rose_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_state == S_FIN))
        else $error("result raised outside of final state");

    // An accepted speed request goes straight to the interval check
    a_speed_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_opcode == OP_SPEED)) |=> (w_state == S_CHECK))
        else $error("speed request did not start calculation");

    // Loading the output register always presents a word
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
